// ===== rtl/sobel_pkg.sv =====
// ----------------------------------------------------------------------------
// sobel_pkg
// Register indexes, fixed-point constants and helpers shared by the Sobel
// edge filter.
// ----------------------------------------------------------------------------
package sobel_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    // Register reset values.
    localparam logic [11:0] RST_IMAGE_WIDTH    = 12'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT   = 13'd480;
    localparam logic [7:0]  RST_HIGH_THRESHOLD = 8'd200;
    localparam logic [7:0]  RST_LOW_THRESHOLD  = 8'd100;

    // Frame height limits.
    localparam logic [12:0] MIN_HEIGHT = 13'd3;
    localparam logic [12:0] MAX_HEIGHT = 13'd4096;

    // Field widths.
    localparam int PIXEL_W   = 24;
    localparam int OUT_PIX_W = 32;
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 11;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;
    localparam logic [7:0]  LUMA_OFFSET  = 8'd16;
    localparam logic [11:0] EDGE_FULL    = 12'd255;

    // BT.601 luma with integer weights; the result always fits in a byte.
    function automatic logic [7:0] rgb_to_luma(input logic [23:0] rgb);
        logic [15:0] sum;
        sum = 16'(16'd66 * rgb[23:16]) + 16'(16'd129 * rgb[15:8])
            + 16'(16'd25 * rgb[7:0]) + 16'd128;
        return sum[15:8] + LUMA_OFFSET;
    endfunction

    function automatic logic [11:0] abs12(input logic signed [11:0] v);
        return v[11] ? 12'(-v) : 12'(v);
    endfunction

endpackage

// ===== rtl/sobel_ram.sv =====
// ----------------------------------------------------------------------------
// sobel_ram
// Simple dual-port RAM: one write port, one read port with registered data
// that holds while the read enable is low.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sobel_edge_filter_3x3_top.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_filter_3x3_top
// Streaming 3x3 Sobel edge filter on BT.601 luma with thresholds.
// ----------------------------------------------------------------------------
// The filter accepts one RGB pixel per clock in raster order and sustains
// that rate indefinitely while the output side keeps taking results. A pixel
// passes three registers: the input register (together with the line store
// read at its column), the luma register and the result register, which
// presents its result. A result that waits stalls the stages behind it, and
// the input stalls once all three registers are occupied. Each pixel gives
// at most one result: row 0 gives zeros, the left column of rows 2 and up
// gives zeros, and interior pixels give the inverted, thresholded edge value
// of the pixel one row up and one column left. The last row never comes out,
// nor the last column outside row 0. The two luma lines live in two RAMs of
// MAX_WIDTH bytes that are not cleared after reset; an entry is always
// written before its value can reach a result. The user must write registers
// only while no pixel is in flight; the block itself does not enforce this.
// Width and height may change inside a frame, where the counters wrap once
// they reach or pass the new limits, but the width must not grow there.
// ----------------------------------------------------------------------------
module sobel_edge_filter_3x3_top
    import sobel_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Pixel input stream.
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [23:0]            s_axis_tdata,   // [23:0] pixel_rgb
    // Edge result stream.
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [55:0]            m_axis_tdata    // [31:0] out_pixel, [43:32] out_row,
                                                   // [54:44] out_col, [55] zero
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LW = ((CW > 12) ? CW : 12) + 1;

    // Configuration registers.
    logic [11:0] r_image_width;
    logic [12:0] r_image_height;
    logic [7:0]  r_high_threshold;
    logic [7:0]  r_low_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= RST_IMAGE_WIDTH;
            r_image_height   <= RST_IMAGE_HEIGHT;
            r_high_threshold <= RST_HIGH_THRESHOLD;
            r_low_threshold  <= RST_LOW_THRESHOLD;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data[11:0];
                REG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data;
                REG_HIGH_THRESHOLD: r_high_threshold <= i_cfg_data[7:0];
                REG_LOW_THRESHOLD:  r_low_threshold  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective frame size, saturated, minus one.
    logic [LW-1:0] width_ext;
    logic [LW-1:0] width_m1;
    logic [12:0]   height_m1;

    always_comb begin
        width_ext = LW'(r_image_width);
        if (width_ext < LW'(3)) begin
            width_ext = LW'(3);
        end else if (width_ext > LW'(MAX_WIDTH)) begin
            width_ext = LW'(MAX_WIDTH);
        end
        width_m1 = width_ext - LW'(1);

        if (r_image_height < MIN_HEIGHT) begin
            height_m1 = MIN_HEIGHT - 13'd1;
        end else if (r_image_height > MAX_HEIGHT) begin
            height_m1 = MAX_HEIGHT - 13'd1;
        end else begin
            height_m1 = r_image_height - 13'd1;
        end
    end

    // Pipeline flow control: each stage moves when the next one is free.
    logic r_v1, r_v2, r_ov;
    logic out_free, s2_go, s2_free, s1_go, s1_free, in_accept;

    assign out_free      = !r_ov || m_axis_tready;
    assign s2_go         = r_v2 && out_free;
    assign s2_free       = !r_v2 || out_free;
    assign s1_go         = r_v1 && s2_free;
    assign s1_free       = !r_v1 || s2_free;
    assign s_axis_tready = s1_free;
    assign in_accept     = s_axis_tvalid && s1_free;

    // Raster position of the next input pixel.
    logic [CW-1:0] r_col;
    logic [11:0]   r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (LW'(r_col) >= width_m1) begin
                r_col <= '0;
                r_row <= ({1'b0, r_row} >= height_m1) ? 12'd0 : r_row + 12'd1;
            end else begin
                r_col <= CW'(r_col + CW'(1));
            end
        end
    end

    // Stage 1: input register; the line store is read in the accept cycle.
    logic [23:0]   r_s1_rgb;
    logic [CW-1:0] r_s1_col;
    logic [11:0]   r_s1_row;
    logic [7:0]    top_rd, mid_rd, luma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_free) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_rgb <= s_axis_tdata;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
        end
    end

    assign luma = rgb_to_luma(r_s1_rgb);

    // The upper line takes the old middle entry, the middle line the new luma.
    sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_top_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (mid_rd),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (top_rd)
    );

    sobel_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_mid_line (
        .i_clk     (i_clk),
        .i_wr_en   (s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (luma),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_data (mid_rd)
    );

    // Stage 2: luma and the two line entries of one column.
    logic [7:0]    r_s2_top, r_s2_mid, r_s2_y;
    logic [CW-1:0] r_s2_col;
    logic [11:0]   r_s2_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_free) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_top <= top_rd;
            r_s2_mid <= mid_rd;
            r_s2_y   <= luma;
            r_s2_col <= r_s1_col;
            r_s2_row <= r_s1_row;
        end
    end

    // 3x3 window, index row*3+col, column 2 newest.
    logic [7:0] r_win [9];
    logic [7:0] n_win [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3]   = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = r_s2_top;
        n_win[5] = r_s2_mid;
        n_win[8] = r_s2_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (s2_go) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // Sobel on the shifted window, then inversion and thresholds.
    logic signed [11:0] gx, gy;
    logic [11:0]        edge_sum;
    logic [7:0]         gray;

    always_comb begin
        gx = - $signed({4'd0, n_win[0]}) + $signed({4'd0, n_win[2]})
             - $signed({3'd0, n_win[3], 1'b0}) + $signed({3'd0, n_win[5], 1'b0})
             - $signed({4'd0, n_win[6]}) + $signed({4'd0, n_win[8]});
        gy =   $signed({4'd0, n_win[0]}) + $signed({3'd0, n_win[1], 1'b0})
             + $signed({4'd0, n_win[2]}) - $signed({4'd0, n_win[6]})
             - $signed({3'd0, n_win[7], 1'b0}) - $signed({4'd0, n_win[8]});
        edge_sum = abs12(gx) + abs12(gy);
        gray = (edge_sum < EDGE_FULL) ? 8'(EDGE_FULL - edge_sum) : 8'd0;
        if (gray > r_high_threshold) begin
            gray = 8'hFF;
        end else if (gray < r_low_threshold) begin
            gray = 8'd0;
        end
    end

    // Result selection by raster position.
    logic        emit;
    logic [31:0] res_pixel;
    logic [11:0] res_row;
    logic [10:0] res_col;

    always_comb begin
        emit      = 1'b0;
        res_pixel = '0;
        res_row   = r_s2_row - 12'd1;
        res_col   = '0;
        if (r_s2_row == 12'd0) begin
            emit    = 1'b1;
            res_row = '0;
            res_col = OUT_COL_W'(r_s2_col);
        end else if (r_s2_row != 12'd1) begin
            if (r_s2_col == '0) begin
                emit = 1'b1;
            end else if (r_s2_col != CW'(1)) begin
                emit      = 1'b1;
                res_pixel = ALPHA_OPAQUE | {8'd0, gray, gray, gray};
                res_col   = OUT_COL_W'(r_s2_col - CW'(1));
            end
        end
    end

    // Result register.
    logic [31:0] r_out_pixel;
    logic [11:0] r_out_row;
    logic [10:0] r_out_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_free) begin
            r_ov <= s2_go && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && emit) begin
            r_out_pixel <= res_pixel;
            r_out_row   <= res_row;
            r_out_col   <= res_col;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_out_col, r_out_row, r_out_pixel};

endmodule

// ===== tb/sobel_edge_filter_3x3_top_test.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_filter_3x3_top_test
// Self-checking testbench for the streaming 3x3 Sobel edge filter. Frames of
// RGB pixels are streamed in under random source and sink idling. A predictor
// follows the luma line store, the window and the frame counters, and every
// result transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sobel_edge_filter_3x3_top_test
    import sobel_pkg::*;
();

    localparam int LINE_MAX      = 2048;
    localparam int HEIGHT_MAX    = 4096;
    localparam int SETTLE        = 8;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int WIDE_PIXELS   = 660;
    localparam int RANDOM_PIXELS = 250;

    typedef struct packed {
        logic [31:0] pixel;
        logic [11:0] row;
        logic [10:0] col;
    } t_edge_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [23:0]            s_axis_tdata = '0;   // [23:0] pixel_rgb
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [55:0]            m_axis_tdata;        // [31:0] out_pixel, [43:32] out_row,
                                                 // [54:44] out_col, [55] zero

    // Predictor state.
    logic [11:0]  width_reg;
    logic [12:0]  height_reg;
    logic [7:0]   high_thr;
    logic [7:0]   low_thr;
    logic [7:0]   line_top [LINE_MAX];
    logic [7:0]   line_mid [LINE_MAX];
    logic [7:0]   win [9];
    int unsigned  next_row;
    int unsigned  next_col;

    t_edge_result edges_due [$];
    int           mismatches = 0;
    int           pixels_sent = 0;
    int           stall_cycles = 0;
    int           drain_hold = 0;
    bit           feed_gaps = 1'b1;
    bit           drain_gaps = 1'b1;

    sobel_edge_filter_3x3_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned active_width();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = height_reg;
        if (h < 3) h = 3;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        return h;
    endfunction

    function automatic logic [7:0] luma_of(input logic [23:0] rgb);
        int sum;
        sum = 66 * int'(rgb[23:16]) + 129 * int'(rgb[15:8]) + 25 * int'(rgb[7:0]) + 128;
        return 8'((sum >> 8) + 16);
    endfunction

    function automatic logic [31:0] edge_gray();
        int p [9];
        int gx;
        int gy;
        int e;
        int v;
        for (int k = 0; k < 9; k++) p[k] = int'(win[k]);
        gx = -p[0] + p[2] - 2 * p[3] + 2 * p[5] - p[6] + p[8];
        gy = p[0] + 2 * p[1] + p[2] - p[6] - 2 * p[7] - p[8];
        e = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        v = (e < 255) ? 255 - e : 0;
        // The high test wins when the thresholds overlap.
        if (v > int'(high_thr)) begin
            v = 255;
        end else if (v < int'(low_thr)) begin
            v = 0;
        end
        return ALPHA_OPAQUE | {8'h00, 8'(v), 8'(v), 8'(v)};
    endfunction

    // Advances the predictor by one accepted pixel and queues its result.
    function automatic void predict_edge(input logic [23:0] rgb);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        logic [7:0]  y;
        logic [7:0]  top;
        logic [7:0]  mid;
        w = active_width();
        h = active_height();
        r = next_row;
        c = next_col;
        y = luma_of(rgb);
        top = line_top[c];
        mid = line_mid[c];
        line_top[c] = mid;
        line_mid[c] = y;
        for (int k = 0; k < 3; k++) begin
            win[k * 3] = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = y;

        if (r == 0) begin
            edges_due.push_back('{pixel: '0, row: '0, col: 11'(c)});
        end else if (r >= 2 && c == 0) begin
            edges_due.push_back('{pixel: '0, row: 12'(r - 1), col: '0});
        end else if (r >= 2 && c >= 2) begin
            edges_due.push_back('{pixel: edge_gray(), row: 12'(r - 1), col: 11'(c - 1)});
        end

        if (c >= w - 1) begin
            next_col = 0;
            next_row = (r >= h - 1) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endfunction

    function automatic logic [23:0] noisy_pixel(input logic [23:0] base, input int spread);
        logic [23:0] px;
        int          ch;
        if (spread >= 255) return 24'($urandom);
        for (int k = 0; k < 3; k++) begin
            ch = int'(base[8 * k +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
            if (ch < 0) ch = 0;
            if (ch > 255) ch = 255;
            px[8 * k +: 8] = 8'(ch);
        end
        return px;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back pixels can be sent without a gap.
    task automatic send_pixel(input logic [23:0] rgb);
        while (feed_gaps && $urandom_range(0, 99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rgb;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_edge(rgb);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int spread);
        logic [23:0] base;
        int          count;
        base = 24'($urandom);
        count = active_width() * active_height();
        repeat (count) send_pixel(noisy_pixel(base, spread));
    endtask

    task automatic complete_frame();
        while (!(next_row == 0 && next_col == 0)) send_pixel(24'($urandom));
    endtask

    // Stops the source and lets every expected result drain out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (edges_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (index)
            REG_IMAGE_WIDTH:    width_reg = value[11:0];
            REG_IMAGE_HEIGHT:   height_reg = value;
            REG_HIGH_THRESHOLD: high_thr = value[7:0];
            REG_LOW_THRESHOLD:  low_thr = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Reset sizes are left in place for a short run, then shrunk mid-row.
    task automatic test_reset_defaults();
        repeat (40) send_pixel(24'($urandom));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd6);
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        complete_frame();
        send_frame(20);
        send_frame(4);
    endtask

    task automatic test_directed_frames();
        logic [23:0] corners [9];
        corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
                    24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F};
        wait_idle();
        // Sizes below the minimum saturate to a 3x3 frame.
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        write_reg(REG_HIGH_THRESHOLD, 13'd255);
        write_reg(REG_LOW_THRESHOLD, 13'd0);
        foreach (corners[k]) send_pixel(corners[k]);
        repeat (9) send_pixel(24'h404040);
        wait_idle();
        write_reg(REG_HIGH_THRESHOLD, 13'd10);
        write_reg(REG_LOW_THRESHOLD, 13'd200);
        for (int k = 0; k < 9; k++) send_pixel({3{8'(8'h10 + 4 * (k / 3))}});
    endtask

    // The saturated width runs the first row past the reset width; the row
    // is then cut short by shrinking the width again.
    task automatic test_wide_row();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'h0FFF);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        repeat (WIDE_PIXELS) send_pixel(24'($urandom));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        complete_frame();
    endtask

    task automatic test_tall_column();
        wait_idle();
        // Bit 12 falls outside the width register.
        write_reg(REG_IMAGE_WIDTH, 13'h1002);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (60) send_pixel(24'($urandom));
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 13'd5);
        complete_frame();
    endtask

    task automatic test_random_frames();
        int stop_at;
        int w;
        int spreads [5];
        spreads = '{2, 8, 25, 70, 255};
        stop_at = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < stop_at) begin
            wait_idle();
            case ($urandom_range(0, 19))
                0:       w = $urandom_range(41, 100);
                1, 2, 3: w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            write_reg(REG_IMAGE_WIDTH, 13'(w) | ($urandom_range(0, 4) == 0 ? 13'h1000 : 13'h0));
            write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(3, 8)));
            case ($urandom_range(0, 5))
                0:       write_reg(REG_HIGH_THRESHOLD, 13'd0);
                1:       write_reg(REG_HIGH_THRESHOLD, 13'd255);
                default: write_reg(REG_HIGH_THRESHOLD, 13'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(REG_LOW_THRESHOLD, 13'd0);
                1:       write_reg(REG_LOW_THRESHOLD, 13'd255);
                default: write_reg(REG_LOW_THRESHOLD, 13'($urandom_range(0, 255)));
            endcase
            repeat ($urandom_range(1, 3)) send_frame(spreads[$urandom_range(0, 4)]);
        end
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd16);
        write_reg(REG_IMAGE_HEIGHT, 13'd6);
        write_reg(REG_HIGH_THRESHOLD, 13'd230);
        write_reg(REG_LOW_THRESHOLD, 13'd40);
        feed_gaps = 1'b0;
        drain_hold = HOLD_CYCLES;
        send_frame(25);
        wait_idle();
        // A long stretch with neither side idling.
        drain_gaps = 1'b0;
        write_reg(REG_IMAGE_WIDTH, 13'd24);
        write_reg(REG_IMAGE_HEIGHT, 13'd8);
        send_frame(10);
        wait_idle();
        feed_gaps = 1'b1;
        drain_gaps = 1'b1;
    endtask

    // Sizes change inside a frame: the counters wrap once they reach or pass
    // the new limits. Growth only returns to columns filled earlier.
    task automatic test_mid_frame_changes();
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd16);
        write_reg(REG_IMAGE_HEIGHT, 13'd8);
        repeat (53) send_pixel(noisy_pixel(24'h606060, 30));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd8);
        repeat (10) send_pixel(noisy_pixel(24'h606060, 30));
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 13'd4);
        repeat (21) send_pixel(noisy_pixel(24'h606060, 30));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 13'd16);
        complete_frame();
    endtask

    // Result side: ready pattern, with an optional long hold-off.
    always @(negedge i_clk) begin
        if (drain_hold > 0) begin
            m_axis_tready <= 1'b0;
            drain_hold--;
        end else begin
            m_axis_tready <= !(drain_gaps && $urandom_range(0, 99) < 35);
        end
    end

    always @(posedge i_clk) begin
        t_edge_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (edges_due.size() == 0) begin
                $error("unexpected result transaction: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = edges_due.pop_front();
                if (m_axis_tdata[31:0] !== want.pixel) begin
                    $error("out_pixel: expected %h, got %h", want.pixel, m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (m_axis_tdata[43:32] !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, m_axis_tdata[43:32]);
                    mismatches++;
                end
                if (m_axis_tdata[54:44] !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, m_axis_tdata[54:44]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        width_reg  = RST_IMAGE_WIDTH;
        height_reg = RST_IMAGE_HEIGHT;
        high_thr   = RST_HIGH_THRESHOLD;
        low_thr    = RST_LOW_THRESHOLD;
        foreach (line_top[k]) begin
            line_top[k] = '0;
            line_mid[k] = '0;
        end
        foreach (win[k]) win[k] = '0;
        next_row = 0;
        next_col = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed_frames();
        test_wide_row();
        test_tall_column();
        test_random_frames();
        test_backpressure();
        test_mid_frame_changes();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && edges_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
